@@ hw/rtl/linked_list_queue_manager_assert.svh @@
// assertion macros for the queue manager rtl
`ifndef LINKED_LIST_QUEUE_MANAGER_ASSERT_SVH
`define LINKED_LIST_QUEUE_MANAGER_ASSERT_SVH

// implication checked on every clock outside reset
`define LLQ_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("llq check failed");

// implication checked in the cycle after the antecedent
`define LLQ_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("llq check failed");

`endif

@@ hw/rtl/llq_pkg.sv @@
`default_nettype none
package llq_pkg;
    localparam int unsigned KindW = 4;
    localparam int unsigned IdxW  = 8;
    localparam int unsigned LenW  = 9;

    // node pool size, every index is taken modulo this
    localparam int unsigned POOL_SIZE = 256;

    typedef enum logic [KindW-1:0] {
        K_NEXT     = 4'd0,
        K_PREV     = 4'd1,
        K_DEL_SUCC = 4'd2,
        K_DEL_PRED = 4'd3,
        K_ROOT     = 4'd4,
        K_AFTER    = 4'd5,
        K_BEFORE   = 4'd6,
        K_DELETE   = 4'd7,
        K_LOCATE   = 4'd8,
        K_COUNT    = 4'd9
    } t_kind;

    // which link table a memory access addresses
    typedef enum logic [1:0] {
        T_NEXT = 2'd0,
        T_PREV = 2'd1,
        T_ROOT = 2'd2
    } t_tab;
endpackage
`default_nettype wire

@@ hw/rtl/linked_list_queue_manager.sv @@
// Linked-list queue manager: one request in, one result out, handled one
// at a time by a sequencer around three single-port link memories (next,
// previous, root), each with a registered read. The pool holds POOL_SIZE
// nodes, a package constant. Each memory read takes an address state, then
// a data state. Reads of a link return it; make root points the node's
// three links at itself; insert after or before reads two links, then
// writes the new ones; the three deletes read two links and splice the node
// out, or stop after the first read when the node is lone; unknown codes go
// straight to the result. Locate and count walk the next links until the
// anchor, the sought node or POOL_SIZE links. A stalled output holds the
// sequencer until the result is taken. After reset a clearing pass writes
// every entry to its own index, with o_stall held high. The result sits in
// an output register and a new request may be taken while it waits.
`default_nettype none
`include "linked_list_queue_manager_assert.svh"
module linked_list_queue_manager (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [llq_pkg::KindW-1:0] i_kind,
    input  wire logic [llq_pkg::IdxW-1:0]  i_anchor,
    input  wire logic [llq_pkg::IdxW-1:0]  i_node,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [llq_pkg::IdxW-1:0]       o_result_index,
    output logic [llq_pkg::LenW-1:0]       o_queue_length,
    output logic                           o_found
);
    import llq_pkg::*;

    localparam int unsigned AW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int unsigned CW  = $clog2(POOL_SIZE + 1);

    typedef logic [AW-1:0] t_addr;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_R1, S_W1, S_R2, S_W2, S_W3,
        S_WR0, S_WR1, S_WR2, S_WR3, S_WR4, S_WR5,
        S_WALK, S_WWAIT, S_DONE
    } t_state;

    t_state r_state;
    t_kind  r_kind;
    t_addr  r_a, r_n, r_x, r_y, r_r;
    t_addr  r_clr;
    logic [CW-1:0] r_cnt;
    logic [IdxW-1:0] r_res;
    logic [LenW-1:0] r_len;
    logic r_fnd, r_ovalid;
    logic [IdxW-1:0] r_ores;
    logic [LenW-1:0] r_olen;
    logic r_ofnd;

    logic [AW-1:0] next_mem [POOL_SIZE];
    logic [AW-1:0] prev_mem [POOL_SIZE];
    logic [AW-1:0] root_mem [POOL_SIZE];
    logic [AW-1:0] r_rdata;

    // one access per cycle
    logic  m_we;
    t_tab  m_tab;
    t_addr m_addr, m_wdata;
    logic  m_clr;

    function automatic t_addr f_idx(input logic [IdxW-1:0] v);
        logic [31:0] w;
        w = 32'(v) % POOL_SIZE;
        return AW'(w);
    endfunction

    always_ff @(posedge i_clk) begin
        if (m_clr) begin
            next_mem[m_addr] <= m_addr;
            prev_mem[m_addr] <= m_addr;
            root_mem[m_addr] <= m_addr;
        end else if (m_we) begin
            case (m_tab)
                T_NEXT:  next_mem[m_addr] <= m_wdata;
                T_PREV:  prev_mem[m_addr] <= m_wdata;
                default: root_mem[m_addr] <= m_wdata;
            endcase
        end
        case (m_tab)
            T_NEXT:  r_rdata <= next_mem[m_addr];
            T_PREV:  r_rdata <= prev_mem[m_addr];
            default: r_rdata <= root_mem[m_addr];
        endcase
    end

    logic out_free;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_result_index = r_ores;
    assign o_queue_length = r_olen;
    assign o_found  = r_ofnd;

    // access plan: clearing pass, reads, and for edits up to six ordered writes
    always_comb begin
        m_we = 1'b0; m_tab = T_NEXT; m_addr = r_a; m_wdata = r_a; m_clr = 1'b0;
        case (r_state)
            S_CLEAR: begin m_clr = 1'b1; m_addr = r_clr; end
            S_R1: begin
                case (r_kind)
                    K_PREV, K_DEL_PRED, K_BEFORE: m_tab = T_PREV;
                    K_AFTER: m_tab = T_ROOT;
                    default: m_tab = T_NEXT;
                endcase
            end
            S_R2: begin
                case (r_kind)
                    K_DEL_SUCC: begin m_tab = T_NEXT; m_addr = r_x; end
                    K_DEL_PRED: begin m_tab = T_PREV; m_addr = r_x; end
                    K_AFTER:  m_tab = T_NEXT;
                    K_BEFORE: m_tab = T_ROOT;
                    default:  m_tab = T_PREV;
                endcase
            end
            S_WALK: begin m_tab = T_NEXT; m_addr = r_x; end
            S_WR0, S_WR1, S_WR2, S_WR3, S_WR4, S_WR5: begin
                m_we = 1'b1;
                case (r_kind)
                    K_AFTER, K_BEFORE: begin
                        case (r_state)
                            S_WR0: begin
                                m_tab = (r_kind == K_AFTER) ? T_NEXT : T_PREV;
                                m_addr = r_a; m_wdata = r_n;
                            end
                            S_WR1: begin
                                m_tab = T_NEXT; m_addr = r_n;
                                m_wdata = (r_kind == K_AFTER) ? r_y : r_a;
                            end
                            S_WR2: begin
                                m_tab = T_PREV; m_addr = r_n;
                                m_wdata = (r_kind == K_AFTER) ? r_a : r_y;
                            end
                            S_WR3: begin m_tab = T_ROOT; m_addr = r_n; m_wdata = r_r; end
                            default: begin
                                m_tab = (r_kind == K_AFTER) ? T_PREV : T_NEXT;
                                m_addr = r_y; m_wdata = r_n;
                            end
                        endcase
                    end
                    K_ROOT: begin
                        m_tab = (r_state == S_WR0) ? T_NEXT :
                                (r_state == S_WR1) ? T_PREV : T_ROOT;
                        m_addr = r_a; m_wdata = r_a;
                    end
                    default: begin
                        // splice: r_y before, r_r after, r_x victim
                        case (r_state)
                            S_WR0: begin m_tab = T_NEXT; m_addr = r_y; m_wdata = r_r; end
                            S_WR1: begin m_tab = T_PREV; m_addr = r_r; m_wdata = r_y; end
                            S_WR2: begin m_tab = T_NEXT; m_addr = r_x; m_wdata = r_x; end
                            S_WR3: begin m_tab = T_PREV; m_addr = r_x; m_wdata = r_x; end
                            default: begin m_tab = T_ROOT; m_addr = r_x; m_wdata = r_x; end
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == POOL_SIZE - 1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= t_kind'(i_kind);
                        r_a <= f_idx(i_anchor);
                        r_n <= f_idx(i_node);
                        r_res <= '0; r_len <= '0; r_fnd <= 1'b0;
                        case (i_kind)
                            K_NEXT, K_PREV, K_DEL_SUCC, K_DEL_PRED, K_AFTER, K_BEFORE,
                            K_DELETE, K_LOCATE, K_COUNT: r_state <= S_R1;
                            K_ROOT: r_state <= S_WR0;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_R1: r_state <= S_W1;
                S_W1: begin
                    case (r_kind)
                        K_NEXT, K_PREV: begin
                            r_res <= IdxW'(r_rdata); r_state <= S_DONE;
                        end
                        K_AFTER: begin r_r <= r_rdata; r_state <= S_R2; end
                        K_LOCATE, K_COUNT: begin
                            r_x <= r_rdata; r_cnt <= CW'(1);
                            if (r_kind == K_LOCATE) r_res <= IdxW'(r_a);
                            else r_len <= LenW'(1);
                            r_state <= S_WWAIT;
                        end
                        default: begin
                            r_x <= r_rdata; r_y <= r_rdata;
                            if (r_kind != K_BEFORE && r_rdata == r_a) r_state <= S_DONE;
                            else r_state <= S_R2;
                        end
                    endcase
                end
                S_R2: r_state <= S_W2;
                S_W2: begin
                    case (r_kind)
                        K_AFTER: begin r_y <= r_rdata; r_state <= S_WR0; end
                        K_BEFORE: begin r_r <= r_rdata; r_state <= S_WR0; end
                        K_DEL_SUCC: begin r_y <= r_a; r_r <= r_rdata; r_state <= S_WR0; end
                        K_DEL_PRED: begin r_y <= r_rdata; r_r <= r_a; r_state <= S_WR0; end
                        default: begin
                            // delete: before = prev(a), after = next(a), victim a
                            r_y <= r_rdata; r_r <= r_x; r_x <= r_a; r_state <= S_WR0;
                        end
                    endcase
                end
                S_WR0: r_state <= S_WR1;
                S_WR1: r_state <= S_WR2;
                S_WR2: r_state <= (r_kind == K_ROOT) ? S_DONE : S_WR3;
                S_WR3: r_state <= S_WR4;
                S_WR4: r_state <= (r_kind == K_AFTER || r_kind == K_BEFORE) ?
                                  S_DONE : S_WR5;
                S_WR5: r_state <= S_DONE;
                S_WWAIT: begin
                    // r_x is the node under test, r_cnt the links taken
                    if (r_x == r_a) begin
                        r_state <= S_DONE;
                    end else if (r_kind == K_LOCATE && r_x == r_n) begin
                        r_res <= IdxW'(r_x); r_fnd <= 1'b1; r_state <= S_DONE;
                    end else if (32'(r_cnt) >= POOL_SIZE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: r_state <= S_W3;
                S_W3: begin
                    r_x <= r_rdata;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_kind == K_COUNT) r_len <= LenW'(r_cnt + 1'b1);
                    r_state <= S_WWAIT;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ores <= r_res;
                        r_olen <= r_len;
                        r_ofnd <= r_fnd;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LLQ_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state == S_CLEAR, o_stall)
    `LLQ_ASSERT_NXT(a_done_out, i_clk, i_rst_n,
        r_state == S_DONE && out_free, o_valid && r_state == S_IDLE)
    `LLQ_ASSERT_IMP(a_found_loc, i_clk, i_rst_n, o_valid && o_found,
        o_queue_length == '0)
    `LLQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_result_index) && $stable(o_queue_length))
endmodule
`default_nettype wire

@@ tb/sv/llq_scoreboard.sv @@
module llq_scoreboard (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic                      i_o_stall,
    input  wire logic [llq_pkg::KindW-1:0] i_kind,
    input  wire logic [llq_pkg::IdxW-1:0]  i_anchor,
    input  wire logic [llq_pkg::IdxW-1:0]  i_node,
    input  wire logic                      i_o_valid,
    input  wire logic                      i_stall,
    input  wire logic [llq_pkg::IdxW-1:0]  i_result_index,
    input  wire logic [llq_pkg::LenW-1:0]  i_queue_length,
    input  wire logic                      i_found,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import llq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Pool = 256;

    typedef struct packed {
        logic [IdxW-1:0] result_index;
        logic [LenW-1:0] queue_length;
        logic            found;
    } t_answer;

    logic [IdxW-1:0] succ_of [Pool];
    logic [IdxW-1:0] pred_of [Pool];
    logic [IdxW-1:0] root_of [Pool];
    t_answer answers_due [$];

    function automatic void make_lone(logic [IdxW-1:0] v);
        succ_of[v] = v;
        pred_of[v] = v;
        root_of[v] = v;
    endfunction

    function automatic void splice_out(logic [IdxW-1:0] lo, logic [IdxW-1:0] hi,
                                       logic [IdxW-1:0] victim);
        succ_of[lo] = hi;
        pred_of[hi] = lo;
        make_lone(victim);
    endfunction

    function automatic t_answer apply_request(logic [KindW-1:0] kind,
                                              logic [IdxW-1:0] a, logic [IdxW-1:0] n);
        t_answer ans;
        logic [IdxW-1:0] x, y, r;
        int len;
        ans = '0;
        case (kind)
            K_NEXT: ans.result_index = succ_of[a];
            K_PREV: ans.result_index = pred_of[a];
            K_DEL_SUCC: begin
                x = succ_of[a];
                if (x != a) begin
                    y = succ_of[x];
                    splice_out(a, y, x);
                end
            end
            K_DEL_PRED: begin
                x = pred_of[a];
                if (x != a) begin
                    y = pred_of[x];
                    splice_out(y, a, x);
                end
            end
            K_ROOT: make_lone(a);
            K_AFTER: begin
                r = root_of[a];
                y = succ_of[a];
                succ_of[a] = n;
                succ_of[n] = y;
                pred_of[n] = a;
                root_of[n] = r;
                pred_of[y] = n;
            end
            K_BEFORE: begin
                r = root_of[a];
                y = pred_of[a];
                pred_of[a] = n;
                succ_of[n] = a;
                pred_of[n] = y;
                root_of[n] = r;
                succ_of[y] = n;
            end
            K_DELETE: begin
                x = succ_of[a];
                if (x != a) begin
                    y = pred_of[a];
                    splice_out(y, x, a);
                end
            end
            K_LOCATE: begin
                x = succ_of[a];
                ans.result_index = a;
                for (int s = 0; s < Pool; s++) begin
                    if (x == a) break;
                    if (x == n) begin
                        ans.result_index = x;
                        ans.found = 1'b1;
                        break;
                    end
                    x = succ_of[x];
                end
            end
            K_COUNT: begin
                len = 1;
                x = succ_of[a];
                while (x != a && len < Pool) begin
                    x = succ_of[x];
                    len++;
                end
                ans.queue_length = LenW'(len);
            end
            default: ;
        endcase
        return ans;
    endfunction

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < Pool; i++) make_lone(IdxW'(i));
            answers_due.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_o_valid && !i_stall) begin
                if (answers_due.size() == 0) begin
                    $display("%t: result with nothing outstanding: idx %0d len %0d found %0d",
                             $time, i_result_index, i_queue_length, i_found);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.result_index !== i_result_index ||
                        want.queue_length !== i_queue_length || want.found !== i_found) begin
                        $display("%t: mismatch expected idx %0d len %0d found %0d, got idx %0d len %0d found %0d",
                                 $time, want.result_index, want.queue_length, want.found,
                                 i_result_index, i_queue_length, i_found);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // transfer in is predicted after the output check of the same edge
            if (i_valid && !i_o_stall)
                answers_due.push_back(apply_request(i_kind, i_anchor, i_node));
        end
    end
endmodule

@@ tb/sv/tb_linked_list_queue_manager.sv @@
module tb_linked_list_queue_manager;
    import llq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    logic [KindW-1:0] req_kind = '0;
    logic [IdxW-1:0] req_anchor = '0;
    logic [IdxW-1:0] req_node = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    logic [IdxW-1:0] rsp_index;
    logic [LenW-1:0] rsp_length;
    logic            rsp_found;
    int              fail_count, pending, checked;
    int              burst_left = 0;
    int              sent = 0;

    always #5 clk = ~clk;

    linked_list_queue_manager u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_kind(req_kind), .i_anchor(req_anchor), .i_node(req_node),
        .o_valid(rsp_valid), .i_stall(rsp_stall),
        .o_result_index(rsp_index), .o_queue_length(rsp_length), .o_found(rsp_found)
    );

    llq_scoreboard u_scoreboard (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .i_o_stall(req_stall),
        .i_kind(req_kind), .i_anchor(req_anchor), .i_node(req_node),
        .i_o_valid(rsp_valid), .i_stall(rsp_stall),
        .i_result_index(rsp_index), .i_queue_length(rsp_length), .i_found(rsp_found),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // receiver back-pressure, mode redrawn at random: none, light, heavy or periodic
    always @(posedge clk) begin
        int cyc, mode;
        cyc = cyc + 1;
        if (cyc % 200 == 0) mode = $urandom_range(0, 3);
        case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ((cyc / 7) % 3 == 0);
        endcase
    end

    task automatic send_request(t_kind kind, int anchor, int node);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_valid  <= 1'b1;
        req_kind   <= kind;
        req_anchor <= IdxW'(anchor);
        req_node   <= IdxW'(node);
        @(posedge clk);
        while (req_stall) @(posedge clk);
        burst_left--;
        sent++;
    endtask

    function automatic int pick_index(int base);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
        return (base + $urandom_range(0, 23)) % 256;
    endfunction

    initial begin
        int base, roll;
        t_kind kind;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_request(K_NEXT, 0, 0);
        send_request(K_PREV, 255, 255);
        send_request(K_COUNT, 255, 0);
        send_request(K_LOCATE, 0, 0);
        send_request(t_kind'(4'd10), 255, 255);
        send_request(t_kind'(4'd15), 170, 85);
        send_request(K_DELETE, 3, 0);
        send_request(K_DEL_SUCC, 4, 0);
        send_request(K_DEL_PRED, 6, 0);
        send_request(K_ROOT, 10, 0);
        send_request(K_AFTER, 10, 20);
        send_request(K_BEFORE, 10, 255);
        send_request(K_AFTER, 20, 0);
        send_request(K_COUNT, 10, 0);
        send_request(K_LOCATE, 10, 0);
        send_request(K_LOCATE, 10, 99);
        send_request(K_LOCATE, 10, 10);
        send_request(K_NEXT, 20, 0);
        send_request(K_PREV, 10, 0);
        // already linked node, then a node beside itself
        send_request(K_AFTER, 255, 20);
        send_request(K_BEFORE, 5, 5);
        send_request(K_DEL_SUCC, 10, 0);
        send_request(K_DEL_PRED, 20, 0);
        send_request(K_DELETE, 0, 0);
        send_request(K_COUNT, 10, 0);

        base = 0;
        for (int i = 0; i < 700; i++) begin
            if (i % 60 == 0) base = $urandom_range(0, 255);
            if (i == 350) begin
                req_valid <= 1'b0;
                burst_left = 0;
                while (pending != 0) @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 20) kind = K_AFTER;
            else if (roll < 35) kind = K_BEFORE;
            else if (roll < 43) kind = K_NEXT;
            else if (roll < 50) kind = K_PREV;
            else if (roll < 57) kind = K_DELETE;
            else if (roll < 63) kind = K_DEL_SUCC;
            else if (roll < 69) kind = K_DEL_PRED;
            else if (roll < 80) kind = K_LOCATE;
            else if (roll < 90) kind = K_COUNT;
            else if (roll < 95) kind = K_ROOT;
            else kind = t_kind'($urandom_range(10, 15));
            send_request(kind, pick_index(base), pick_index(base));
        end
        req_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("run covered %0d requests over every operation and unknown codes,", sent);
        $display("%0d results checked under random gaps and back-pressure", checked);
        if (fail_count == 0)
            $display("tb_linked_list_queue_manager: PASS");
        else
            $display("tb_linked_list_queue_manager: FAIL");
        $finish;
    end

    initial begin
        #30ms;
        $display("tb_linked_list_queue_manager: FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/llq_pkg.sv
hw/rtl/linked_list_queue_manager.sv
tb/sv/llq_scoreboard.sv
tb/sv/tb_linked_list_queue_manager.sv
